/* sv/cht_pkg.sv */
// Package for the two-table cuckoo hash block: opcodes, status codes,
// register indexes and defaults. No dependencies.
package cht_pkg;

  localparam int unsigned DefTableDepth = 1024;
  localparam int unsigned DefKeyBits    = 32;
  localparam int unsigned DefValueBits  = 32;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_CHANGE = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_PRESENT = 2'd2;
  localparam logic [1:0] ST_FAILED  = 2'd3;

  localparam logic [2:0] REG_H1_MUL = 3'd0;
  localparam logic [2:0] REG_H1_ADD = 3'd1;
  localparam logic [2:0] REG_H2_MUL = 3'd2;
  localparam logic [2:0] REG_H2_ADD = 3'd3;
  localparam logic [2:0] REG_KICKS  = 3'd4;

  localparam logic [31:0] H1_MUL_RESET = 32'd2654435769;
  localparam logic [31:0] H2_MUL_RESET = 32'd2246822519;
  localparam logic [6:0]  KICKS_RESET  = 7'd16;

endpackage

/* sv/cht_hash.sv */
// Registered multiply-add-shift hash: one product per cycle; product and index are both registered.
// Depends on cht_pkg.
module cht_hash import cht_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DefTableDepth,
  parameter int unsigned KEY_BITS    = DefKeyBits,
  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                clk,
  input  logic [KEY_BITS-1:0] key,
  input  logic [31:0]         mul,
  input  logic [31:0]         add,
  output logic [IW-1:0]       index
);

  logic [31:0] prod;
  logic [31:0] h;
  logic [IW:0] raw;
  logic [KEY_BITS+31:0] key_ext;

  assign key_ext = {32'd0, key};

  // Stage one: low 32 bits of the product.
  always_ff @(posedge clk) begin
    prod <= mul * key_ext[31:0];
  end

  // Stage two: add, take the top index bits, fold once into the depth.
  always_comb begin
    h   = prod + add;
    raw = {1'b0, h[31 -: IW]};
    if (raw >= (IW+1)'(TABLE_DEPTH)) begin
      raw = raw - (IW+1)'(TABLE_DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    index <= raw[IW-1:0];
  end

endmodule

/* sv/cht_table.sv */
// One cuckoo table: key, value and valid memories with registered reads, and a
// clearing pass over the valid memory after reset. Depends on cht_pkg.
module cht_table import cht_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DefTableDepth,
  parameter int unsigned KEY_BITS    = DefKeyBits,
  parameter int unsigned VALUE_BITS  = DefValueBits,
  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IW-1:0]         rd_addr,
  output logic [KEY_BITS-1:0]   rd_key,
  output logic [VALUE_BITS-1:0] rd_value,
  output logic                  rd_valid,
  input  logic                  wr_key_en,
  input  logic                  wr_value_en,
  input  logic [IW-1:0]         wr_addr,
  input  logic [KEY_BITS-1:0]   wr_key,
  input  logic [VALUE_BITS-1:0] wr_value,
  input  logic                  set_en,
  input  logic                  clr_en,
  output logic                  clearing
);

  logic [KEY_BITS-1:0]   keys   [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] values [TABLE_DEPTH];
  logic                  valid  [TABLE_DEPTH];
  logic [IW-1:0]         clr_addr;

  // Memory ports.
  always_ff @(posedge clk) begin
    if (wr_key_en) begin
      keys[wr_addr] <= wr_key;
    end
    if (wr_value_en) begin
      values[wr_addr] <= wr_value;
    end
    rd_key   <= keys[rd_addr];
    rd_value <= values[rd_addr];
  end

  // Clearing pass: one valid entry per cycle, starting when reset is released.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == IW'(TABLE_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Valid memory.
  always_ff @(posedge clk) begin
    if (clearing) begin
      valid[clr_addr] <= 1'b0;
    end else if (set_en) begin
      valid[wr_addr] <= 1'b1;
    end else if (clr_en) begin
      valid[wr_addr] <= 1'b0;
    end
    rd_valid <= valid[rd_addr];
  end

endmodule

/* sv/cuckoo_hash_table.sv */
// Top level of the two-table cuckoo hash map: control sequencer, hash units,
// tables and result register. Depends on cht_pkg, cht_hash and cht_table.
//
//  channel   direction  handshake          payload
//  input     in         in_valid/in_ready  opcode, key, value
//  output    out        out_valid/out_ready status, found, value_out,
//                                          evicted_key, evicted_value, entry_count
//  config    in         cfg_we             cfg_index, cfg_data
//
// Lookup, remove and change give their result after two hash stages, one memory
// read, one compare with write-back and one result load.
// An insert that misses visits table one in the cycle after the compare; each
// further visit adds two hash stages, a read and a place or swap,
// up to 2*max_kicks visits. A new word is taken only once the result register is empty.
// Reset clears the count and state and loads the configuration defaults; the valid
// memories are then cleared in a pass during which in_ready stays low.
module cuckoo_hash_table import cht_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DefTableDepth,
  parameter int unsigned KEY_BITS    = DefKeyBits,
  parameter int unsigned VALUE_BITS  = DefValueBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [31:0] key,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        found,
  output logic [31:0] value_out,
  output logic [31:0] evicted_key,
  output logic [31:0] evicted_value,
  output logic [11:0] entry_count,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_H0    = 4'd1;  // hash stage one
  localparam logic [3:0] S_H1    = 4'd2;  // hash stage two
  localparam logic [3:0] S_RD    = 4'd3;  // memory read
  localparam logic [3:0] S_CMP   = 4'd4;  // probe result
  localparam logic [3:0] S_KH0   = 4'd5;  // kick: hash carried key
  localparam logic [3:0] S_KH1   = 4'd6;
  localparam logic [3:0] S_KRD   = 4'd7;
  localparam logic [3:0] S_KSWAP = 4'd8;  // kick: place or swap
  localparam logic [3:0] S_DONE  = 4'd9;

  // Configuration registers.
  logic [31:0] h1_mul, h1_add, h2_mul, h2_add;
  logic [6:0]  max_kicks;

  always_ff @(posedge clk) begin
    if (rst) begin
      h1_mul    <= H1_MUL_RESET;
      h1_add    <= '0;
      h2_mul    <= H2_MUL_RESET;
      h2_add    <= '0;
      max_kicks <= KICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_H1_MUL: h1_mul    <= cfg_data;
        REG_H1_ADD: h1_add    <= cfg_data;
        REG_H2_MUL: h2_mul    <= cfg_data;
        REG_H2_ADD: h2_add    <= cfg_data;
        REG_KICKS:  max_kicks <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Working registers.
  logic [3:0]            state;
  logic [1:0]            op;
  logic [KEY_BITS-1:0]   cur_key;
  logic [VALUE_BITS-1:0] cur_val;
  logic [VALUE_BITS-1:0] new_val;
  logic                  side;     // table being visited during kicks
  logic [6:0]            rounds;
  logic [11:0]           occupancy;

  logic [IW-1:0] idx1, idx2;
  logic [KEY_BITS-1:0]   k1, k2;
  logic [VALUE_BITS-1:0] v1, v2;
  logic                  ok1, ok2;
  logic                  clr1, clr2;

  cht_hash #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_BITS(KEY_BITS)) u_hash1 (
    .clk(clk), .key(cur_key), .mul(h1_mul), .add(h1_add), .index(idx1));
  cht_hash #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_BITS(KEY_BITS)) u_hash2 (
    .clk(clk), .key(cur_key), .mul(h2_mul), .add(h2_add), .index(idx2));

  // Table write controls.
  logic                  t1_kw, t1_vw, t1_set, t1_clr;
  logic                  t2_kw, t2_vw, t2_set, t2_clr;
  logic [VALUE_BITS-1:0] wr_val;

  cht_table #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_BITS(KEY_BITS),
              .VALUE_BITS(VALUE_BITS)) u_t1 (
    .clk(clk), .rst(rst), .rd_addr(idx1), .rd_key(k1), .rd_value(v1),
    .rd_valid(ok1), .wr_key_en(t1_kw), .wr_value_en(t1_vw), .wr_addr(idx1),
    .wr_key(cur_key), .wr_value(wr_val), .set_en(t1_set), .clr_en(t1_clr),
    .clearing(clr1));
  cht_table #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_BITS(KEY_BITS),
              .VALUE_BITS(VALUE_BITS)) u_t2 (
    .clk(clk), .rst(rst), .rd_addr(idx2), .rd_key(k2), .rd_value(v2),
    .rd_valid(ok2), .wr_key_en(t2_kw), .wr_value_en(t2_vw), .wr_addr(idx2),
    .wr_key(cur_key), .wr_value(wr_val), .set_en(t2_set), .clr_en(t2_clr),
    .clearing(clr2));

  logic hit1, hit2, hit;
  assign hit1 = ok1 && (k1 == cur_key);
  assign hit2 = !hit1 && ok2 && (k2 == cur_key);
  assign hit  = hit1 || hit2;

  // Writes happen in the probe and swap states; reads there are already latched.
  always_comb begin
    t1_kw = 1'b0; t1_vw = 1'b0; t1_set = 1'b0; t1_clr = 1'b0;
    t2_kw = 1'b0; t2_vw = 1'b0; t2_set = 1'b0; t2_clr = 1'b0;
    wr_val = cur_val;
    if (state == S_CMP && hit) begin
      wr_val = new_val;
      if (op == OP_REMOVE) begin
        t1_clr = hit1;
        t2_clr = hit2;
      end else if (op == OP_CHANGE) begin
        t1_vw = hit1;
        t2_vw = hit2;
      end
    end else if (state == S_KSWAP) begin
      if (!side) begin
        t1_kw = 1'b1; t1_vw = 1'b1; t1_set = !ok1;
      end else begin
        t2_kw = 1'b1; t2_vw = 1'b1; t2_set = !ok2;
      end
    end
  end

  logic sel_ok;
  assign sel_ok = side ? ok2 : ok1;

  // The result register must be empty, so the payload never moves while it waits.
  assign in_ready = (state == S_IDLE) && !out_valid && !clr1 && !clr2;

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      occupancy <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op      <= opcode;
            cur_key <= KEY_BITS'(key);
            cur_val <= VALUE_BITS'(value);
            new_val <= VALUE_BITS'(value);
            state   <= S_H0;
          end
        end
        S_H0: state <= S_H1;
        S_H1: state <= S_RD;
        S_RD: state <= S_CMP;
        S_CMP: begin
          found         <= hit;
          status        <= ST_OK;
          value_out     <= '0;
          evicted_key   <= '0;
          evicted_value <= '0;
          state         <= S_DONE;
          if (op == OP_INSERT) begin
            if (hit) begin
              status <= ST_PRESENT;
            end else if (max_kicks == 7'd0) begin
              status        <= ST_FAILED;
              evicted_key   <= 32'(cur_key);
              evicted_value <= 32'(cur_val);
            end else begin
              side   <= 1'b0;
              rounds <= '0;
              state  <= S_KSWAP;
            end
          end else if (!hit) begin
            status <= ST_MISSING;
          end else if (op == OP_LOOKUP) begin
            value_out <= 32'(hit1 ? v1 : v2);
          end else if (op == OP_REMOVE) begin
            occupancy <= occupancy - 12'd1;
          end
        end
        S_KH0: state <= S_KH1;
        S_KH1: state <= S_KRD;
        S_KRD: state <= S_KSWAP;
        S_KSWAP: begin
          if (!sel_ok) begin
            occupancy <= occupancy + 12'd1;
            state     <= S_DONE;
          end else begin
            cur_key <= side ? k2 : k1;
            cur_val <= side ? v2 : v1;
            side    <= !side;
            if (side && (rounds + 7'd1 >= max_kicks)) begin
              status        <= ST_FAILED;
              evicted_key   <= 32'(k2);
              evicted_value <= 32'(v2);
              state         <= S_DONE;
            end else begin
              if (side) begin
                rounds <= rounds + 7'd1;
              end
              state <= S_KH0;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign entry_count = occupancy;

  // Checks.
  a_idle_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_H0) else $error("accept did not start");
  a_ready_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ready) else $error("ready while busy");
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !((t1_kw || t1_clr) && (t2_kw || t2_clr))) else $error("both tables written");
  a_kick_limit: assert property (@(posedge clk) disable iff (rst)
    state == S_KSWAP |-> rounds < max_kicks) else $error("kick count overrun");

endmodule

/* dv/tb.sv */
// Self-checking testbench for the two-table cuckoo hash map.
// Depends on cht_pkg and cuckoo_hash_table; predicts every result word in a scoreboard class.
`timescale 1ns / 1ps

module tb;
  import cht_pkg::*;

  localparam int unsigned Depth = 1024;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [31:0] value_out;
    logic [31:0] evicted_key;
    logic [31:0] evicted_value;
    logic [11:0] entry_count;
  } result_t;

  int unsigned mismatches = 0;

  // Prints one line per mismatch and counts it.
  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("tb: mismatch in %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  // Mirror of the hash map that predicts each result word and holds the queue of them.
  class cuckoo_scoreboard;
    logic [31:0] one_keys [Depth];
    logic [31:0] one_vals [Depth];
    bit          one_used [Depth];
    logic [31:0] two_keys [Depth];
    logic [31:0] two_vals [Depth];
    bit          two_used [Depth];
    logic [11:0] count;
    logic [31:0] m1, a1, m2, a2;
    logic [6:0]  kicks;
    result_t     pending[$];

    function new();
      foreach (one_used[i]) begin
        one_used[i] = 0;
        two_used[i] = 0;
      end
      count = 0;
      m1 = H1_MUL_RESET;
      a1 = 0;
      m2 = H2_MUL_RESET;
      a2 = 0;
      kicks = KICKS_RESET;
    endfunction

    function logic [9:0] slot(input logic [31:0] mul, input logic [31:0] add,
                              input logic [31:0] k);
      logic [31:0] h;
      h = mul * k + add;
      return h[31:22];
    endfunction

    function void set_reg(input logic [2:0] idx, input logic [31:0] d);
      case (idx)
        REG_H1_MUL: m1 = d;
        REG_H1_ADD: a1 = d;
        REG_H2_MUL: m2 = d;
        REG_H2_ADD: a2 = d;
        REG_KICKS:  kicks = d[6:0];
        default: ;
      endcase
    endfunction

    // Notes an accepted word and queues its expected result.
    function void note_word(input logic [1:0] op, input logic [31:0] k, input logic [31:0] v);
      logic [9:0]  p1, p2, a;
      bit          hit1, hit2, placed;
      logic [31:0] ck, cv, tk, tv;
      result_t     r;
      p1 = slot(m1, a1, k);
      p2 = slot(m2, a2, k);
      hit1 = one_used[p1] && one_keys[p1] == k;
      hit2 = !hit1 && two_used[p2] && two_keys[p2] == k;
      r = '0;
      r.found = hit1 || hit2;
      if (op == OP_INSERT) begin
        if (r.found) begin
          r.status = ST_PRESENT;
        end else begin
          ck = k;
          cv = v;
          placed = 0;
          for (int i = 0; i < kicks && !placed; i++) begin
            a = slot(m1, a1, ck);
            if (!one_used[a]) begin
              one_keys[a] = ck; one_vals[a] = cv; one_used[a] = 1;
              placed = 1;
            end else begin
              tk = one_keys[a]; tv = one_vals[a];
              one_keys[a] = ck; one_vals[a] = cv;
              ck = tk; cv = tv;
              a = slot(m2, a2, ck);
              if (!two_used[a]) begin
                two_keys[a] = ck; two_vals[a] = cv; two_used[a] = 1;
                placed = 1;
              end else begin
                tk = two_keys[a]; tv = two_vals[a];
                two_keys[a] = ck; two_vals[a] = cv;
                ck = tk; cv = tv;
              end
            end
          end
          if (placed) begin
            count++;
          end else begin
            r.status = ST_FAILED;
            r.evicted_key = ck;
            r.evicted_value = cv;
          end
        end
      end else if (!r.found) begin
        r.status = ST_MISSING;
      end else if (op == OP_LOOKUP) begin
        r.value_out = hit1 ? one_vals[p1] : two_vals[p2];
      end else if (op == OP_REMOVE) begin
        if (hit1) one_used[p1] = 0;
        else two_used[p2] = 0;
        count--;
      end else begin
        if (hit1) one_vals[p1] = v;
        else two_vals[p2] = v;
      end
      r.entry_count = count;
      pending.push_back(r);
    endfunction

    // Compares one result word with the oldest expectation.
    task check_word(input result_t got);
      result_t want;
      if (pending.size() == 0) begin
        report("unexpected word", 0, 0);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.found !== want.found) report("found", got.found, want.found);
      if (got.value_out !== want.value_out) report("value_out", got.value_out, want.value_out);
      if (got.evicted_key !== want.evicted_key)
        report("evicted_key", got.evicted_key, want.evicted_key);
      if (got.evicted_value !== want.evicted_value)
        report("evicted_value", got.evicted_value, want.evicted_value);
      if (got.entry_count !== want.entry_count)
        report("entry_count", got.entry_count, want.entry_count);
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  opcode = OP_INSERT;
  logic [31:0] key = 0;
  logic [31:0] value = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  status;
  logic        found;
  logic [31:0] value_out;
  logic [31:0] evicted_key;
  logic [31:0] evicted_value;
  logic [11:0] entry_count;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = REG_H1_MUL;
  logic [31:0] cfg_data = 0;

  cuckoo_scoreboard board = new();
  bit no_idle = 0;
  logic [31:0] key_pool[$];

  cuckoo_hash_table u_dut (.*);

  always #5 clk = ~clk;

  // Result side: random stalls, checks each accepted word.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_word({status, found, value_out, evicted_key, evicted_value, entry_count});
    out_ready <= rst ? 1'b0 : (no_idle || $urandom_range(99) >= 13);
  end

  // Valid stays high after an accept until the next word or an idle cycle replaces it.
  task automatic send_word(input logic [1:0] op, input logic [31:0] k, input logic [31:0] v);
    while (!no_idle && $urandom_range(99) < 13) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    opcode <= op;
    key <= k;
    value <= v;
    do @(posedge clk); while (!in_ready);
    board.note_word(op, k, v);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    // An insert may run up to 2*127 visits.
    repeat (1000) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    board.set_reg(idx, d);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // Picks a key: mostly one already used, so hits, updates and removes happen.
  function automatic logic [31:0] pick_key();
    logic [31:0] k;
    if (key_pool.size() != 0 && $urandom_range(99) < 60) begin
      k = key_pool[$urandom_range(key_pool.size() - 1)];
    end else begin
      k = $urandom();
      if (key_pool.size() < 400) key_pool.push_back(k);
    end
    return k;
  endfunction

  task automatic random_phase(input int n, input int insert_pct);
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(99) < insert_pct) ? OP_INSERT : 2'($urandom_range(1, 3));
      send_word(op, pick_key(), $urandom());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: field extremes, every operation and the special cases.
    send_word(OP_LOOKUP, 32'h0, 32'h0);
    send_word(OP_INSERT, 32'h0, 32'hFFFFFFFF);
    send_word(OP_INSERT, 32'h0, 32'h1);
    send_word(OP_LOOKUP, 32'h0, 32'h0);
    send_word(OP_INSERT, 32'hFFFFFFFF, 32'h0);
    send_word(OP_CHANGE, 32'hFFFFFFFF, 32'hA5A5A5A5);
    send_word(OP_LOOKUP, 32'hFFFFFFFF, 32'h0);
    send_word(OP_CHANGE, 32'h12345678, 32'h1);
    send_word(OP_REMOVE, 32'h12345678, 32'h0);
    send_word(OP_REMOVE, 32'h0, 32'h0);
    send_word(OP_LOOKUP, 32'h0, 32'h0);
    // Pause the sender until every expected word has come.
    drain();

    // Degenerate hashes force collisions: every key shares both slots.
    write_reg(REG_H1_MUL, 32'h0);
    write_reg(REG_H1_ADD, 32'hFFFFFFFF);
    write_reg(REG_H2_MUL, 32'h0);
    write_reg(REG_H2_ADD, 32'h0);
    write_reg(REG_KICKS, 32'd1);
    for (int i = 0; i < 6; i++) send_word(OP_INSERT, 32'(i + 100), 32'(i));
    send_word(OP_LOOKUP, 32'd100, 32'h0);
    send_word(OP_LOOKUP, 32'd101, 32'h0);
    drain();
    write_reg(REG_KICKS, 32'd0);
    send_word(OP_INSERT, 32'd200, 32'd7);
    drain();
    write_reg(3'd7, 32'hFFFFFFFF);
    write_reg(REG_KICKS, 32'd127);
    send_word(OP_INSERT, 32'd201, 32'd8);
    drain();

    // Random phases through several register settings.
    write_reg(REG_H1_MUL, 32'hFFFFFFFF);
    write_reg(REG_H1_ADD, 32'h0);
    write_reg(REG_H2_MUL, 32'h1);
    write_reg(REG_H2_ADD, 32'hFFFFFFFF);
    write_reg(REG_KICKS, 32'd64);
    random_phase(400, 45);
    drain();
    no_idle = 1;
    random_phase(200, 40);
    no_idle = 0;
    drain();
    // Few slot bits used: crowded tables hit kick limits.
    write_reg(REG_H1_MUL, 32'h00400001);
    write_reg(REG_H1_ADD, $urandom());
    write_reg(REG_H2_MUL, 32'h00C00003);
    write_reg(REG_H2_ADD, $urandom());
    write_reg(REG_KICKS, 32'd3);
    random_phase(400, 50);
    drain();
    write_reg(REG_H1_MUL, $urandom() | 1);
    write_reg(REG_H2_MUL, $urandom() | 1);
    write_reg(REG_KICKS, 32'd16);
    random_phase(500, 40);
    drain();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("tb: failure");
    $finish;
  end

endmodule

/* cuckoo_hash_table.f */
sv/cht_pkg.sv
sv/cht_hash.sv
sv/cht_table.sv
sv/cuckoo_hash_table.sv
dv/tb.sv
